@@ sv/lmp_pkg.sv @@
// Shared constants and types for the LED matrix PWM scanner.
// No dependencies; imported by led_matrix_pwm_scanner.
`timescale 1ns / 1ps
`default_nettype none

package lmp_pkg;

  // matrix geometry and PWM depth
  localparam int ROWS    = 7;
  localparam int COLUMNS = 18;
  localparam int STEPS   = 16;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 5;
  localparam int STEP_W  = 4;
  localparam int INT_W   = 8;

  // intensity scaling: (v * STEPS + ROUND) >> SCALE_SHIFT
  localparam int ROUND       = 128;
  localparam int SCALE_SHIFT = 8;
  localparam int SCALE_W     = INT_W + STEP_W + 1;

  // command codes
  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_PIXEL = 2'd1,
    FUNC_SET_ROW   = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_t;

  typedef logic [COLUMNS-1:0] col_bits_t;
  typedef logic [COLUMNS-1:0][STEP_W-1:0] row_steps_t;

  // off step for a pixel write: at least 1, and full scale means never (0)
  function automatic logic [STEP_W-1:0] off_step_of(input logic [INT_W-1:0] v);
    logic [SCALE_W-1:0] scaled;
    logic [SCALE_W-SCALE_SHIFT-1:0] s;
    logic [STEP_W-1:0] res;
    scaled = SCALE_W'(v) * SCALE_W'(STEPS) + SCALE_W'(ROUND);
    s = scaled[SCALE_W-1:SCALE_SHIFT];
    if (s == '0) begin
      res = STEP_W'(1);
    end else if (s >= (SCALE_W-SCALE_SHIFT)'(STEPS)) begin
      res = '0;
    end else begin
      res = s[STEP_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/led_matrix_pwm_scanner.sv @@
// Top level of the row-multiplexed LED matrix driver with PWM dimming.
// Depends on lmp_pkg for geometry constants, command codes and scaling.
//
// Usage:
//   Command channel: a word (func, column, row, intensity, bitmap) is taken at
//   each rising edge with start high and busy low. busy is always low, so a
//   word may be issued in every cycle.
//   Result channel: done pulses for one cycle; in that cycle row_on,
//   active_row and columns_lit show the scanner state after the word.
//   Every word, of every kind, gives exactly one result.
// Pipeline and throughput:
//   start passes through one input register, then one state update to done.
//   One word per cycle sustained; the pixel store is flip-flops written and
//   read within the single update stage.
// Reset (rst, synchronous, active high) clears all pixels, the scan counters
// and the column drive, and drops done. The receiver cannot stall: each
// result is valid only during its done cycle.
// Writes with an out-of-range row or column leave the state unchanged.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_pwm_scanner
  import lmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [COL_W-1:0]   column,
  input  wire logic [ROW_W-1:0]   row,
  input  wire logic [INT_W-1:0]   intensity,
  input  wire logic [COLUMNS-1:0] bitmap,
  output logic                    done,
  output logic                    row_on,
  output logic [ROW_W-1:0]        active_row,
  output logic [COLUMNS-1:0]      columns_lit
);

  // input register
  logic               valid_q;
  func_t              func_q;
  logic [COL_W-1:0]   column_q;
  logic [ROW_W-1:0]   row_q;
  logic [INT_W-1:0]   intensity_q;
  logic [COLUMNS-1:0] bitmap_q;

  // pixel store and scan state
  col_bits_t  lit   [ROWS];
  row_steps_t off   [ROWS];
  logic [ROW_W-1:0]  scan_row;
  logic [STEP_W-1:0] scan_step;
  logic              row_strobed;
  col_bits_t         column_drive;

  // tick decode
  logic              wrap;
  logic [ROW_W-1:0]  row_next;
  logic [STEP_W-1:0] step_next;
  logic [ROW_W-1:0]  rd_row;
  col_bits_t         rd_lit;
  row_steps_t        rd_off;
  col_bits_t         off_hit;
  logic [STEP_W-1:0] new_off;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
    func_q      <= func_t'(func);
    column_q    <= column;
    row_q       <= row;
    intensity_q <= intensity;
    bitmap_q    <= bitmap;
  end

  // next scan position
  always_comb begin
    wrap      = (scan_step == STEP_W'(STEPS - 1));
    step_next = wrap ? '0 : scan_step + STEP_W'(1);
    row_next  = (scan_row == ROW_W'(ROWS - 1)) ? '0 : scan_row + ROW_W'(1);
    rd_row    = wrap ? row_next : scan_row;
    rd_lit    = '0;
    rd_off    = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (rd_row == ROW_W'(r)) begin
        rd_lit = lit[r];
        rd_off = off[r];
      end
    end
    for (int c = 0; c < COLUMNS; c++) begin
      off_hit[c] = (rd_off[c] == step_next);
    end
    new_off = off_step_of(intensity_q);
  end

  // state update, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      scan_row     <= '0;
      scan_step    <= '0;
      row_strobed  <= 1'b0;
      column_drive <= '0;
      for (int r = 0; r < ROWS; r++) begin
        lit[r] <= '0;
        off[r] <= '0;
      end
    end else begin
      done <= valid_q;
      if (valid_q) begin
        unique case (func_q)
          FUNC_TICK: begin
            scan_step <= step_next;
            if (wrap) begin
              scan_row     <= row_next;
              row_strobed  <= 1'b1;
              column_drive <= rd_lit;
            end else begin
              column_drive <= column_drive & ~off_hit;
            end
          end
          FUNC_SET_PIXEL: begin
            for (int r = 0; r < ROWS; r++) begin
              for (int c = 0; c < COLUMNS; c++) begin
                if (row_q == ROW_W'(r) && column_q == COL_W'(c)) begin
                  lit[r][c] <= (intensity_q != '0);
                  off[r][c] <= new_off;
                end
              end
            end
          end
          FUNC_SET_ROW: begin
            for (int r = 0; r < ROWS; r++) begin
              if (row_q == ROW_W'(r)) begin
                lit[r] <= bitmap_q;
                off[r] <= '0;
              end
            end
          end
          FUNC_CLEAR: begin
            for (int r = 0; r < ROWS; r++) begin
              lit[r] <= '0;
              off[r] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign row_on      = row_strobed;
  assign active_row  = scan_row;
  assign columns_lit = column_drive;

  // checks
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    active_row <= ROW_W'(ROWS - 1))
    else $error("active row out of range");

  a_row_before_strobe: assert property (@(posedge clk) disable iff (rst)
    !row_on |-> (active_row == '0 && columns_lit == '0))
    else $error("scan moved before first strobe");

  a_strobe_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(row_on) |-> $past(valid_q && func_q == FUNC_TICK))
    else $error("row strobed without a tick");

  a_drive_on_tick: assert property (@(posedge clk) disable iff (rst)
    (!$stable(columns_lit) && !$past(rst)) |-> $past(valid_q && func_q == FUNC_TICK))
    else $error("column drive changed without a tick");

endmodule

`default_nettype wire
